### rtl/ebcc_pkg.sv
// Shared types, constants and helper functions of the encoder bank.
`timescale 1ns / 1ps

package ebcc_pkg;

	localparam int IN_WIDTH     = 16;
	localparam int COUNT_W      = 8;
	localparam int SHOWN_LEVELS = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int REG_IDX_W    = 2;

	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_LIMIT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOUND_LIMIT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_VALUE_LIMIT   = 2'd2;

	localparam logic [COUNT_W-1:0] CHANNEL_LIMIT_RST = 8'd16;
	localparam logic [COUNT_W-1:0] SOUND_LIMIT_RST   = 8'd8;
	localparam logic [COUNT_W-1:0] VALUE_LIMIT_RST   = 8'd255;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	// Classified snapshot, minus the per-level steps
	typedef struct packed {
		step_t main_step;
		logic  toggle;
		logic  action;
	} cls_t;

	typedef struct packed {
		logic [COUNT_W-1:0] channel;
		logic [COUNT_W-1:0] sound;
		logic [COUNT_W-1:0] value;
	} limits_t;

	// Positions past the switch count or the input width read as zero
	function automatic logic sw_bit(input logic [IN_WIDTH-1:0] v, input int pos,
			input int nbits);
		logic r;
		r = 1'b0;
		if (pos < nbits && pos < IN_WIDTH)
			r = v[pos[$clog2(IN_WIDTH)-1:0]];
		return r;
	endfunction

	function automatic step_t enc_step(input logic a1, input logic a0,
			input logic b1, input logic b0);
		step_t s;
		s = STEP_NONE;
		if ((a1 == a0 && a1 == b0 && b0 != b1) || (b1 == b0 && b1 == a1 && b1 != a0))
			s = STEP_UP;
		else if ((b1 == b0 && b1 == a0 && a0 != a1) ||
				(a1 == a0 && a1 == b1 && a1 != b0))
			s = STEP_DOWN;
		return s;
	endfunction

	// Counter update; a zero step still snaps down to a lowered limit
	function automatic logic [COUNT_W-1:0] clamp_step(input logic [COUNT_W-1:0] cur,
			input step_t s, input logic [COUNT_W-1:0] lim);
		logic [COUNT_W-1:0] r;
		case (s)
			STEP_UP: r = (cur >= lim) ? lim : cur + 1'b1;
			STEP_DOWN: begin
				if (cur == '0)
					r = '0;
				else
					r = ((cur - 1'b1) > lim) ? lim : cur - 1'b1;
			end
			default: r = (cur > lim) ? lim : cur;
		endcase
		return r;
	endfunction

endpackage

### rtl/ebcc_front.sv
// Front end: keeps the previous snapshot and classifies each new one.
`timescale 1ns / 1ps

module ebcc_front #(
	parameter int SWITCH_BITS = 16,
	parameter int NUM_LEVELS  = 4,
	parameter int PUSH_BIT    = 2,
	parameter int ACTION_BIT  = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [ebcc_pkg::IN_WIDTH-1:0]   switch_vector,
	output ebcc_pkg::cls_t                  cls,
	output ebcc_pkg::step_t [NUM_LEVELS-1:0] lvl_steps
);
	import ebcc_pkg::*;

	logic [IN_WIDTH-1:0] prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= switch_vector;
		end
	end

	always_comb begin
		cls.main_step = enc_step(sw_bit(switch_vector, 0, SWITCH_BITS),
				sw_bit(prev_q, 0, SWITCH_BITS),
				sw_bit(switch_vector, 1, SWITCH_BITS),
				sw_bit(prev_q, 1, SWITCH_BITS));
		cls.toggle = sw_bit(switch_vector, PUSH_BIT, SWITCH_BITS) &
				~sw_bit(prev_q, PUSH_BIT, SWITCH_BITS);
		cls.action = sw_bit(switch_vector, ACTION_BIT, SWITCH_BITS);
	end

	for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_lvl
		localparam int PA = 3 * i + 3;
		assign lvl_steps[i] = enc_step(sw_bit(switch_vector, PA, SWITCH_BITS),
				sw_bit(prev_q, PA, SWITCH_BITS),
				sw_bit(switch_vector, PA + 1, SWITCH_BITS),
				sw_bit(prev_q, PA + 1, SWITCH_BITS));
	end

endmodule

### rtl/ebcc_queue.sv
// Short register queue between the front and back ends.
`timescale 1ns / 1ps

module ebcc_queue #(
	parameter int WIDTH = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	import ebcc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

### rtl/ebcc_back.sv
// Back end: applies classified steps to the clamped counters, holds the result.
`timescale 1ns / 1ps

module ebcc_back #(
	parameter int NUM_LEVELS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ebcc_pkg::limits_t                limits,
	input  logic                             q_empty,
	input  ebcc_pkg::cls_t                   cls,
	input  ebcc_pkg::step_t [NUM_LEVELS-1:0] lvl_steps,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             action_pressed,
	output logic                             sound_mode,
	output logic [ebcc_pkg::COUNT_W-1:0]     channel_out,
	output logic [ebcc_pkg::COUNT_W-1:0]     sound_out,
	output logic [ebcc_pkg::COUNT_W-1:0]     level_out [NUM_LEVELS]
);
	import ebcc_pkg::*;

	logic               valid_q;
	logic               action_q;
	logic               adjust_q;
	logic [COUNT_W-1:0] channel_q;
	logic [COUNT_W-1:0] sound_q;
	logic [COUNT_W-1:0] level_q [NUM_LEVELS];
	logic               adjust_n;

	assign pop      = !q_empty && (!valid_q || !out_stall);
	assign adjust_n = adjust_q ^ cls.toggle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			adjust_q  <= 1'b0;
			channel_q <= '0;
			sound_q   <= '0;
			for (int i = 0; i < NUM_LEVELS; i++)
				level_q[i] <= '0;
		end else begin
			if (pop) begin
				valid_q  <= 1'b1;
				adjust_q <= adjust_n;
				if (adjust_n)
					sound_q <= clamp_step(sound_q, cls.main_step, limits.sound);
				else
					channel_q <= clamp_step(channel_q, cls.main_step, limits.channel);
				for (int i = 0; i < NUM_LEVELS; i++)
					level_q[i] <= clamp_step(level_q[i], lvl_steps[i], limits.value);
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			action_q <= cls.action;
	end

	assign out_valid      = valid_q;
	assign action_pressed = action_q;
	assign sound_mode     = adjust_q;
	assign channel_out    = channel_q;
	assign sound_out      = sound_q;
	assign level_out      = level_q;

`ifndef SYNTHESIS
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q) else $error("result missing after pop");
	a_main_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (adjust_q ? (sound_q <= $past(limits.sound))
				: (channel_q <= $past(limits.channel))))
		else $error("selected counter above its limit");
	a_level_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> level_q[0] <= $past(limits.value)) else $error("level above limit");
`endif

endmodule

### rtl/encoder_bank_clamped_counters_top.sv
// Top level of the quadrature encoder bank with clamped counters.
//
// Input channel: in_valid / in_stall carry one switch_vector snapshot per
// transaction. Output channel: out_valid / out_stall carry one result per
// snapshot: action level, sound/channel mode, channel and sound counters and
// the value counters, all as they stand after that snapshot.
// Limits are written through wr_en / wr_index / wr_data while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
// The front end compares each snapshot with the previous one and pushes the
// encoder steps into a two-entry queue; the back end pops one entry a cycle
// while out_stall is low and updates the selected channel or sound counter and
// every value counter. Throughput: one snapshot per cycle while out_stall is
// low, set by the single counter-update stage. When the receiver stalls, the
// result register holds and the queue fills; in_stall rises once both queue
// entries are taken. Reset clears the previous snapshot, the mode and all
// counters to zero and loads the limits with 16, 8 and 255.
`timescale 1ns / 1ps

module encoder_bank_clamped_counters_top #(
	parameter int SWITCH_BITS = 16,
	parameter int NUM_LEVELS  = 4,
	parameter int PUSH_BIT    = 2,
	parameter int ACTION_BIT  = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ebcc_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [ebcc_pkg::COUNT_W-1:0]      wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ebcc_pkg::IN_WIDTH-1:0]     switch_vector,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              action_pressed,
	output logic                              sound_mode,
	output logic [ebcc_pkg::COUNT_W-1:0]      channel_out,
	output logic [ebcc_pkg::COUNT_W-1:0]      sound_out,
	output logic [ebcc_pkg::COUNT_W-1:0]      value_0,
	output logic [ebcc_pkg::COUNT_W-1:0]      value_1,
	output logic [ebcc_pkg::COUNT_W-1:0]      value_2,
	output logic [ebcc_pkg::COUNT_W-1:0]      value_3
);
	import ebcc_pkg::*;

	localparam int Q_WIDTH = $bits(cls_t) + $bits(step_t) * NUM_LEVELS;

	limits_t                limits_q;
	cls_t                   f_cls;
	step_t [NUM_LEVELS-1:0] f_steps;
	cls_t                   b_cls;
	step_t [NUM_LEVELS-1:0] b_steps;
	logic [Q_WIDTH-1:0]     q_in;
	logic [Q_WIDTH-1:0]     q_out;
	logic                   q_full;
	logic                   q_empty;
	logic                   pop;
	logic                   in_accept;
	logic [COUNT_W-1:0]     level_out [NUM_LEVELS];
	logic [COUNT_W-1:0]     shown [SHOWN_LEVELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.channel <= CHANNEL_LIMIT_RST;
			limits_q.sound   <= SOUND_LIMIT_RST;
			limits_q.value   <= VALUE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CHANNEL_LIMIT: limits_q.channel <= wr_data;
				REG_SOUND_LIMIT:   limits_q.sound   <= wr_data;
				REG_VALUE_LIMIT:   limits_q.value   <= wr_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	ebcc_front #(
		.SWITCH_BITS (SWITCH_BITS),
		.NUM_LEVELS  (NUM_LEVELS),
		.PUSH_BIT    (PUSH_BIT),
		.ACTION_BIT  (ACTION_BIT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.switch_vector (switch_vector),
		.cls           (f_cls),
		.lvl_steps     (f_steps)
	);

	assign q_in             = {f_cls, f_steps};
	assign {b_cls, b_steps} = q_out;

	ebcc_queue #(
		.WIDTH (Q_WIDTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (q_in),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	ebcc_back #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.limits         (limits_q),
		.q_empty        (q_empty),
		.cls            (b_cls),
		.lvl_steps      (b_steps),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action_pressed (action_pressed),
		.sound_mode     (sound_mode),
		.channel_out    (channel_out),
		.sound_out      (sound_out),
		.level_out      (level_out)
	);

	for (genvar k = 0; k < SHOWN_LEVELS; k++) begin : g_shown
		if (k < NUM_LEVELS) begin : g_have
			assign shown[k] = level_out[k];
		end else begin : g_none
			assign shown[k] = '0;
		end
	end

	assign value_0 = shown[0];
	assign value_1 = shown[1];
	assign value_2 = shown[2];
	assign value_3 = shown[3];

endmodule

### verif/tb.sv
// Self-checking testbench for the encoder bank with clamped counters.
`timescale 1ns / 1ps

module tb;
	import ebcc_pkg::*;

	localparam int PUSH_POS     = 2;
	localparam int ACTION_POS   = 15;
	localparam int NUM_LV       = 4;
	localparam int NUM_ENC      = NUM_LV + 1;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 5000;
	localparam logic [IN_WIDTH-1:0] SPARE_MASK = 16'h4920;

	typedef struct packed {
		logic                         action;
		logic                         mode;
		logic [COUNT_W-1:0]           channel;
		logic [COUNT_W-1:0]           sound;
		logic [NUM_LV-1:0][COUNT_W-1:0] levels;
	} panel_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = REG_CHANNEL_LIMIT;
	logic [COUNT_W-1:0]   wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [IN_WIDTH-1:0]  switch_vector = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 action_pressed;
	logic                 sound_mode;
	logic [COUNT_W-1:0]   channel_out;
	logic [COUNT_W-1:0]   sound_out;
	logic [COUNT_W-1:0]   value_0;
	logic [COUNT_W-1:0]   value_1;
	logic [COUNT_W-1:0]   value_2;
	logic [COUNT_W-1:0]   value_3;

	encoder_bank_clamped_counters_top u_top (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .switch_vector(switch_vector),
		.out_valid(out_valid), .out_stall(out_stall),
		.action_pressed(action_pressed), .sound_mode(sound_mode),
		.channel_out(channel_out), .sound_out(sound_out),
		.value_0(value_0), .value_1(value_1), .value_2(value_2), .value_3(value_3)
	);

	always #5 clk = ~clk;

	logic [IN_WIDTH-1:0] snapshot_queue [$];
	panel_state_t        pending_results [$];
	int                  errors = 0;
	logic                calm = 1'b0;

	// panel predictor state
	logic [COUNT_W-1:0]  chan_lim = CHANNEL_LIMIT_RST;
	logic [COUNT_W-1:0]  snd_lim  = SOUND_LIMIT_RST;
	logic [COUNT_W-1:0]  val_lim  = VALUE_LIMIT_RST;
	logic [IN_WIDTH-1:0] last_sw  = '0;
	logic                sound_sel = 1'b0;
	logic [COUNT_W-1:0]  chan_cnt = '0;
	logic [COUNT_W-1:0]  snd_cnt  = '0;
	logic [COUNT_W-1:0]  lvl_cnt [NUM_LV];

	// stimulus walk state
	logic [IN_WIDTH-1:0] walk_sw = '0;
	int                  dir_bias [NUM_ENC];
	logic                hold_dir = 1'b0;

	function automatic int turn_of(input logic a1, input logic a0, input logic b1,
			input logic b0);
		if ((a1 == a0 && a1 == b0 && b0 != b1) || (b1 == b0 && b1 == a1 && b1 != a0))
			return 1;
		if ((b1 == b0 && b1 == a0 && a0 != a1) || (a1 == a0 && a1 == b1 && a1 != b0))
			return -1;
		return 0;
	endfunction

	function automatic logic [COUNT_W-1:0] bounded(input logic [COUNT_W-1:0] cur,
			input int d, input logic [COUNT_W-1:0] lim);
		int v;
		v = int'(cur) + d;
		if (v < 0)
			v = 0;
		if (v > int'(lim))
			v = int'(lim);
		return v[COUNT_W-1:0];
	endfunction

	task automatic advance_panel(input logic [IN_WIDTH-1:0] now);
		panel_state_t r;
		int           d;
		int           pa;
		if (now[PUSH_POS] && !last_sw[PUSH_POS])
			sound_sel = ~sound_sel;
		d = turn_of(now[0], last_sw[0], now[1], last_sw[1]);
		if (sound_sel)
			snd_cnt = bounded(snd_cnt, d, snd_lim);
		else
			chan_cnt = bounded(chan_cnt, d, chan_lim);
		for (int i = 0; i < NUM_LV; i++) begin
			pa = 3 * i + 3;
			lvl_cnt[i] = bounded(lvl_cnt[i],
				turn_of(now[pa], last_sw[pa], now[pa+1], last_sw[pa+1]), val_lim);
		end
		last_sw = now;
		r.action = now[ACTION_POS];
		r.mode = sound_sel;
		r.channel = chan_cnt;
		r.sound = snd_cnt;
		for (int i = 0; i < NUM_LV; i++)
			r.levels[i] = lvl_cnt[i];
		pending_results.push_back(r);
	endtask

	task automatic flag(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v)
			flag($sformatf("%s expected %0d got %0d", name, exp_v, got_v));
	endtask

	// input side
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				advance_panel(switch_vector);
			if (!in_valid || !in_stall) begin
				if (snapshot_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
					in_valid <= 1'b1;
					switch_vector <= snapshot_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		panel_state_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					flag("result with no transaction pending");
				end else begin
					e = pending_results.pop_front();
					check_field("action_pressed", int'(e.action), int'(action_pressed));
					check_field("sound_mode", int'(e.mode), int'(sound_mode));
					check_field("channel_out", int'(e.channel), int'(channel_out));
					check_field("sound_out", int'(e.sound), int'(sound_out));
					check_field("value_0", int'(e.levels[0]), int'(value_0));
					check_field("value_1", int'(e.levels[1]), int'(value_1));
					check_field("value_2", int'(e.levels[2]), int'(value_2));
					check_field("value_3", int'(e.levels[3]), int'(value_3));
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 10);
		end
	end

	// watchdog
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_item(input logic [IN_WIDTH-1:0] v);
		snapshot_queue.push_back(v);
		walk_sw = v;
	endtask

	// mostly well-formed quadrature walks, with some raw noise
	task automatic next_item(output logic [IN_WIDTH-1:0] v);
		int pa;
		int pos;
		int r;
		v = walk_sw;
		for (int k = 0; k < NUM_ENC; k++) begin
			pa = 3 * k;
			if (!hold_dir && $urandom_range(0, 99) < 1)
				dir_bias[k] = -dir_bias[k];
			r = $urandom_range(0, 99);
			pos = 2 * int'(v[pa]) + int'(v[pa] ^ v[pa+1]);
			if (r < 65)
				pos = pos + dir_bias[k];
			else if (r < 75)
				pos = pos - dir_bias[k];
			pos = pos & 3;
			v[pa] = pos[1];
			v[pa+1] = pos[1] ^ pos[0];
		end
		if ($urandom_range(0, 99) < 8)
			v[PUSH_POS] = ~v[PUSH_POS];
		v[ACTION_POS] = 1'($urandom_range(0, 1));
		v = (v & ~SPARE_MASK) | (IN_WIDTH'($urandom) & SPARE_MASK);
		if ($urandom_range(0, 99) < 12)
			v = IN_WIDTH'($urandom_range(0, 65535));
	endtask

	task automatic run_items(input int n);
		logic [IN_WIDTH-1:0] v;
		@(negedge clk);
		repeat (n) begin
			next_item(v);
			push_item(v);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (snapshot_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limits(input logic [COUNT_W-1:0] ch, input logic [COUNT_W-1:0] snd,
			input logic [COUNT_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_CHANNEL_LIMIT;
		wr_data <= ch;
		@(posedge clk);
		wr_index <= REG_SOUND_LIMIT;
		wr_data <= snd;
		@(posedge clk);
		wr_index <= REG_VALUE_LIMIT;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		chan_lim = ch;
		snd_lim = snd;
		val_lim = val;
	endtask

	logic [IN_WIDTH-1:0] directed [] = '{
		16'h0000,
		16'h0002, 16'h0003, 16'h0001, 16'h0000,          // main forward
		16'h0001, 16'h0003, 16'h0002, 16'h0000, 16'h0001, // main back, clamp at 0
		16'h0004, 16'h0006, 16'h0007, 16'h0003, 16'h0004, // push toggles mode
		16'h0000, 16'h2492, 16'h36DB, 16'h1249, 16'h0000, // all encoders forward
		16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF
	};

	initial begin
		for (int i = 0; i < NUM_LV; i++)
			lvl_cnt[i] = '0;
		for (int k = 0; k < NUM_ENC; k++)
			dir_bias[k] = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i])
			push_item(directed[i]);
		run_items(300);
		wait_idle();

		set_limits(8'd0, 8'd0, 8'd0);
		run_items(150);
		wait_idle();

		// steady climb to the top without idling
		set_limits(8'd255, 8'd255, 8'd255);
		calm = 1'b1;
		hold_dir = 1'b1;
		for (int k = 0; k < NUM_ENC; k++)
			dir_bias[k] = 1;
		run_items(550);
		wait_idle();
		calm = 1'b0;
		hold_dir = 1'b0;

		// counters snap down to lowered limits
		set_limits(8'd5, 8'd200, 8'd3);
		run_items(300);
		wait_idle();

		set_limits(8'd255, 8'd1, 8'd128);
		run_items(300);
		wait_idle();

		set_limits(8'd2, 8'd2, 8'd1);
		run_items(250);
		wait_idle();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/ebcc_pkg.sv
rtl/ebcc_front.sv
rtl/ebcc_queue.sv
rtl/ebcc_back.sv
rtl/encoder_bank_clamped_counters_top.sv
verif/tb.sv
